>>> rtl/exp_quadratic_ramp_eval_defines.svh
// ----------------------------------------------------------------------------
// Ramp evaluator assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef EXP_QUADRATIC_RAMP_EVAL_DEFINES_SVH
`define EXP_QUADRATIC_RAMP_EVAL_DEFINES_SVH

// same-cycle implication
`define EQR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define EQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/eqr_pkg.sv
// ----------------------------------------------------------------------------
// Ramp evaluator package
// Shared constants, register codes and pipeline structs.
// ----------------------------------------------------------------------------
package eqr_pkg;

    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [32:0] ONE_Q30    = 33'h0_4000_0000;
    localparam int          EXP_TERMS  = 12;
    localparam int          K_BIAS     = 93;
    // K_BIAS * ln2 in Q30, keeps the reduced argument non-negative
    localparam logic [38:0] K_BIAS_OFS = 39'(64'd93 * 64'd744261118);
    // floor(2^46 / ln2_q30), reciprocal used on bits [37:22] of the argument
    localparam logic [16:0] RECIP_LN2  = 17'((64'd1 << 46) / 64'd744261118);
    localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_GOAL     = 3'd0,
        REG_RATE     = 3'd1,
        REG_EXP_ORG  = 3'd2,
        REG_QUAD     = 3'd3,
        REG_LIN      = 3'd4,
        REG_CONST    = 3'd5,
        REG_POLY_ORG = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] goal_level;
        logic [31:0] exp_rate;
        logic [31:0] exp_origin;
        logic [31:0] quad_coef;
        logic [31:0] lin_coef;
        logic [31:0] const_term;
        logic [31:0] poly_origin;
    } cfg_t;

    // values that ride along the exponential pipeline
    typedef struct packed {
        logic [7:0]  kb;    // biased power-of-two exponent
        logic        big;   // argument above the limit
        logic        tiny;  // argument below the limit
        logic [32:0] dx1;   // signed offset for the polynomial terms
    } exp_side_t;

endpackage

>>> rtl/eqr_front.sv
// ----------------------------------------------------------------------------
// Ramp evaluator front end
// Offsets, exponent argument and range reduction by ln2, five stages.
// ----------------------------------------------------------------------------
`include "exp_quadratic_ramp_eval_defines.svh"

module eqr_front
    import eqr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] x_sample,
    input  cfg_t               cfg,
    output logic               out_valid,
    output logic [29:0]        out_r,
    output exp_side_t          out_side
);

    localparam logic [64:0] FRAC_MASK = (65'd1 << FRAC_BITS) - 65'd1;
    localparam logic [64:0] ARG_LIM   = 65'd64 << FRAC_BITS;
    localparam int          ZQ_SHIFT  = 30 - FRAC_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [32:0] dx0_reg, dx0_next;
    logic [32:0]        dx1_1_reg, dx1_next;
    logic [64:0]        um_reg, um_next;
    logic               neg_reg, neg_next;
    logic [32:0]        dx1_2_reg;
    logic [37:0]        zs_reg, zs_next;
    logic               big_reg, big_next, tiny_reg, tiny_next;
    logic [32:0]        dx1_3_reg;
    logic [32:0]        prod_reg, prod_next;
    logic [37:0]        zs4_reg;
    logic               big4_reg, tiny4_reg;
    logic [32:0]        dx1_4_reg;
    logic [29:0]        r_reg, r_next;
    logic [7:0]         kb_reg, kb_next;
    logic               big5_reg, tiny5_reg;
    logic [32:0]        dx1_5_reg;

    logic [32:0] rate_neg;
    logic [31:0] rate_mag;
    logic [33:0] dx0_neg;
    logic [32:0] dx0_mag;
    logic        rate_pos, rate_ngt;
    logic [64:0] q, qr, zmag;
    logic        rem;
    logic [38:0] zq, zs_wide;
    logic [7:0]  est;
    logic [37:0] r0;

    // stage 1: offsets
    assign dx0_next = $signed({x_sample[31], x_sample})
                    - $signed({cfg.exp_origin[31], cfg.exp_origin});
    assign dx1_next = 33'($signed({x_sample[31], x_sample})
                    - $signed({cfg.poly_origin[31], cfg.poly_origin}));

    // stage 2: magnitude product for the exponent argument
    assign rate_neg = 33'd0 - {cfg.exp_rate[31], cfg.exp_rate};
    assign rate_mag = cfg.exp_rate[31] ? rate_neg[31:0] : cfg.exp_rate;
    assign dx0_neg  = 34'd0 - {dx0_reg[32], dx0_reg};
    assign dx0_mag  = dx0_reg[32] ? dx0_neg[32:0] : dx0_reg;
    assign um_next  = 65'(rate_mag) * 65'(dx0_mag);
    assign rate_pos = !cfg.exp_rate[31] && (cfg.exp_rate != 32'd0);
    assign rate_ngt = cfg.exp_rate[31];
    assign neg_next = (rate_pos && !dx0_reg[32] && (dx0_reg != 33'sd0))
                   || (rate_ngt && dx0_reg[32]);

    // stage 3: floor to fraction bits, limit check, biased Q30 argument
    assign q         = um_reg >> FRAC_BITS;
    assign rem       = (um_reg & FRAC_MASK) != 65'd0;
    assign qr        = q + 65'(rem);
    assign big_next  = !neg_reg && (q > ARG_LIM);
    assign tiny_next = neg_reg && (qr > ARG_LIM);
    assign zmag      = neg_reg ? qr : q;
    assign zq        = zmag[38:0] << ZQ_SHIFT;
    assign zs_wide   = neg_reg ? (K_BIAS_OFS - zq) : (K_BIAS_OFS + zq);
    // park out-of-range arguments at zero so the reduction stays in range
    assign zs_next   = (big_next || tiny_next) ? K_BIAS_OFS[37:0] : zs_wide[37:0];

    // stage 4: quotient estimate by reciprocal
    assign prod_next = 33'(zs_reg[37:22]) * 33'(RECIP_LN2);

    // stage 5: remainder, one correction step
    always_comb
    begin
        est = prod_reg[31:24];
        r0  = zs4_reg - 38'(est) * 38'(LN2_Q30);
        if (r0 >= 38'(LN2_Q30))
        begin
            r_next  = 30'(r0 - 38'(LN2_Q30));
            kb_next = est + 8'd1;
        end
        else
        begin
            r_next  = r0[29:0];
            kb_next = est;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx0_reg   <= dx0_next;
            dx1_1_reg <= dx1_next;
            um_reg    <= um_next;
            neg_reg   <= neg_next;
            dx1_2_reg <= dx1_1_reg;
            zs_reg    <= zs_next;
            big_reg   <= big_next;
            tiny_reg  <= tiny_next;
            dx1_3_reg <= dx1_2_reg;
            prod_reg  <= prod_next;
            zs4_reg   <= zs_reg;
            big4_reg  <= big_reg;
            tiny4_reg <= tiny_reg;
            dx1_4_reg <= dx1_3_reg;
            r_reg     <= r_next;
            kb_reg    <= kb_next;
            big5_reg  <= big4_reg;
            tiny5_reg <= tiny4_reg;
            dx1_5_reg <= dx1_4_reg;
        end
    end

    assign out_valid     = v5_reg;
    assign out_r         = r_reg;
    assign out_side.kb   = kb_reg;
    assign out_side.big  = big5_reg;
    assign out_side.tiny = tiny5_reg;
    assign out_side.dx1  = dx1_5_reg;

    `EQR_ASSERT_IMP(a_rem_below_ln2, clk, rst_n, v5_reg, r_reg < LN2_Q30)

endmodule

>>> rtl/eqr_horner_step.sv
// ----------------------------------------------------------------------------
// Ramp evaluator Horner step
// One term p = 1 + (r*p)/DIV of the exponential series, three stages.
// ----------------------------------------------------------------------------
`include "exp_quadratic_ramp_eval_defines.svh"

module eqr_horner_step
    import eqr_pkg::*;
#(
    parameter int DIV = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [29:0] in_r,
    input  logic [32:0] in_p,
    input  exp_side_t   in_side,
    output logic        out_valid,
    output logic [29:0] out_r,
    output logic [32:0] out_p,
    output exp_side_t   out_side
);

    // floor(2^32 / DIV)
    localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / DIV);

    logic        va_reg, vb_reg, vc_reg;
    logic [32:0] v_a_reg, v_b_reg;
    logic [65:0] vr_reg, vr_next;
    logic [29:0] r_a_reg, r_b_reg, r_c_reg;
    exp_side_t   s_a_reg, s_b_reg, s_c_reg;
    logic [32:0] p_reg, p_next;
    logic [62:0] rp;
    logic [32:0] v_next;
    logic [32:0] est;
    logic [36:0] rem;
    logic [32:0] q;

    // stage A: r*p in Q30, truncate
    assign rp      = 63'(in_r) * 63'(in_p);
    assign v_next  = rp[62:30];

    // stage B: reciprocal product
    assign vr_next = 66'(v_a_reg) * 66'(RECIP);

    // stage C: correct the estimate, add one
    always_comb
    begin
        est    = vr_reg[64:32];
        rem    = 37'(v_b_reg) - 37'(est) * 37'(DIV);
        q      = est + 33'(rem >= 37'(DIV));
        p_next = ONE_Q30 + q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_a_reg <= v_next;
            r_a_reg <= in_r;
            s_a_reg <= in_side;
            vr_reg  <= vr_next;
            v_b_reg <= v_a_reg;
            r_b_reg <= r_a_reg;
            s_b_reg <= s_a_reg;
            p_reg   <= p_next;
            r_c_reg <= r_b_reg;
            s_c_reg <= s_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_r     = r_c_reg;
    assign out_p     = p_reg;
    assign out_side  = s_c_reg;

    // partial series never reaches two
    `EQR_ASSERT_IMP(a_p_below_two, clk, rst_n, vc_reg, p_reg[32:31] == 2'b00)

endmodule

>>> rtl/eqr_back.sv
// ----------------------------------------------------------------------------
// Ramp evaluator back end
// Exponent shift, term products, final sum and saturation, three stages.
// ----------------------------------------------------------------------------
`include "exp_quadratic_ramp_eval_defines.svh"

module eqr_back
    import eqr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [32:0]        in_p,
    input  exp_side_t          in_side,
    input  cfg_t               cfg,
    output logic               out_valid,
    output logic signed [31:0] y_value,
    output logic               overflow
);

    localparam int                 SH_OFS = FRAC_BITS - 30 - K_BIAS;
    localparam logic signed [33:0] ONE_F  = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [66:0] SUM_MAX = 67'sd2147483647;
    localparam logic signed [66:0] SUM_MIN = -67'sd2147483648;

    logic v1_reg, v2_reg, v3_reg;

    logic signed [33:0] om_reg, om_next;
    logic               ovf1_reg, eovf;
    logic [65:0]        uu_reg, uu_next;
    logic [32:0]        dx1_1_reg;
    logic signed [65:0] pe_reg, pe_next;
    logic signed [64:0] pq_reg, pq_next;
    logic signed [64:0] pl_reg, pl_next;
    logic               ovf2_reg, ovf2_next;
    logic signed [31:0] y_reg, y_next;
    logic               ovf3_reg, ovf3_next;

    logic signed [9:0]  sh;
    logic [9:0]         amt;
    logic [31:0]        pc, e;
    logic [33:0]        dneg;
    logic [32:0]        u;
    logic [65:0]        sqm;
    logic [31:0]        sq;
    logic               sq_ovf;
    logic signed [65:0] te;
    logic signed [64:0] tq, tl;
    logic signed [66:0] sum;

    // stage 1: scale the series by 2^k
    assign sh = $signed({2'b00, in_side.kb}) + 10'(SH_OFS);
    assign pc = (in_p[32:31] != 2'b00) ? SAT_MAX : {1'b0, in_p[30:0]};

    always_comb
    begin
        amt  = 10'd0 - sh;
        e    = 32'd0;
        eovf = 1'b0;
        if (in_side.big)
        begin
            e    = SAT_MAX;
            eovf = 1'b1;
        end
        else if (in_side.tiny)
        begin
            e = 32'd0;
        end
        else if (sh > 10'sd0)
        begin
            e    = SAT_MAX;
            eovf = 1'b1;
        end
        else if (sh == 10'sd0)
        begin
            e = pc;
        end
        else if (amt >= 10'd32)
        begin
            e = 32'd0;
        end
        else
        begin
            e = pc >> amt[4:0];
        end
    end

    assign om_next = ONE_F - $signed({2'b00, e});
    assign dneg    = 34'd0 - {in_side.dx1[32], in_side.dx1};
    assign u       = in_side.dx1[32] ? dneg[32:0] : in_side.dx1;
    assign uu_next = 66'(u) * 66'(u);

    // stage 2: clamp the square, form the three products
    always_comb
    begin
        sqm    = uu_reg >> FRAC_BITS;
        sq_ovf = sqm > 66'(SAT_MAX);
        sq     = sq_ovf ? SAT_MAX : sqm[31:0];
    end

    assign pe_next   = 66'($signed(cfg.goal_level)) * 66'(om_reg);
    assign pq_next   = 65'($signed(cfg.quad_coef)) * 65'($signed({1'b0, sq}));
    assign pl_next   = 65'($signed(cfg.lin_coef)) * 65'($signed(dx1_1_reg));
    assign ovf2_next = ovf1_reg || sq_ovf;

    // stage 3: floor each term, sum, saturate
    always_comb
    begin
        te  = pe_reg >>> FRAC_BITS;
        tq  = pq_reg >>> FRAC_BITS;
        tl  = pl_reg >>> FRAC_BITS;
        sum = 67'(te) + 67'(tq) + 67'(tl) + 67'($signed(cfg.const_term));
        ovf3_next = ovf2_reg;
        if (sum > SUM_MAX)
        begin
            y_next    = 32'sh7FFF_FFFF;
            ovf3_next = 1'b1;
        end
        else if (sum < SUM_MIN)
        begin
            y_next    = -32'sh8000_0000;
            ovf3_next = 1'b1;
        end
        else
        begin
            y_next = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            om_reg    <= om_next;
            ovf1_reg  <= eovf;
            uu_reg    <= uu_next;
            dx1_1_reg <= in_side.dx1;
            pe_reg    <= pe_next;
            pq_reg    <= pq_next;
            pl_reg    <= pl_next;
            ovf2_reg  <= ovf2_next;
            y_reg     <= y_next;
            ovf3_reg  <= ovf3_next;
        end
    end

    assign out_valid = v3_reg;
    assign y_value   = y_reg;
    assign overflow  = ovf3_reg;

    `EQR_ASSERT_NEXT(a_big_flags, clk, rst_n, en && in_valid && in_side.big, ovf1_reg)

endmodule

>>> rtl/exp_quadratic_ramp_eval.sv
// ----------------------------------------------------------------------------
// Ramp model evaluator, top level
// Stages from the input beat to the result beat: 5 front,
// 12 series terms of 3 stages each, 3 back.
// Throughput: one beat per cycle; the 12-term series pipeline sets the depth.
// A result held by out_ready freezes the whole pipeline.
// Reset clears the valid bits and the coefficient registers to zero.
// ----------------------------------------------------------------------------
`include "exp_quadratic_ramp_eval_defines.svh"

module exp_quadratic_ramp_eval
    import eqr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] y_value,
    output logic               overflow
);

    cfg_t      cfg_reg;
    logic      en;
    logic      hv [0:EXP_TERMS];
    logic [29:0] hr [0:EXP_TERMS];
    logic [32:0] hp [0:EXP_TERMS];
    exp_side_t hs [0:EXP_TERMS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GOAL:     cfg_reg.goal_level  <= cfg_data;
                REG_RATE:     cfg_reg.exp_rate    <= cfg_data;
                REG_EXP_ORG:  cfg_reg.exp_origin  <= cfg_data;
                REG_QUAD:     cfg_reg.quad_coef   <= cfg_data;
                REG_LIN:      cfg_reg.lin_coef    <= cfg_data;
                REG_CONST:    cfg_reg.const_term  <= cfg_data;
                REG_POLY_ORG: cfg_reg.poly_origin <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // advance everything unless the result beat is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    eqr_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .x_sample  (x_sample),
        .cfg       (cfg_reg),
        .out_valid (hv[0]),
        .out_r     (hr[0]),
        .out_side  (hs[0])
    );

    assign hp[0] = ONE_Q30;

    for (genvar j = 0; j < EXP_TERMS; j++)
    begin : g_term
        eqr_horner_step #(
            .DIV (EXP_TERMS - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (hv[j]),
            .in_r      (hr[j]),
            .in_p      (hp[j]),
            .in_side   (hs[j]),
            .out_valid (hv[j+1]),
            .out_r     (hr[j+1]),
            .out_p     (hp[j+1]),
            .out_side  (hs[j+1])
        );
    end

    eqr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv[EXP_TERMS]),
        .in_p      (hp[EXP_TERMS]),
        .in_side   (hs[EXP_TERMS]),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .y_value   (y_value),
        .overflow  (overflow)
    );

    // drop writes to the unused index
    `EQR_ASSERT_NEXT(a_cfg_unused_index, clk, rst_n, cfg_valid && cfg_index > REG_POLY_ORG, $stable(cfg_reg))

endmodule

>>> verif/exp_quadratic_ramp_eval_tb.sv
// ----------------------------------------------------------------------------
// Ramp evaluator testbench
// Drives abscissa beats through the evaluator under several coefficient
// settings and idle patterns, predicts each result in fixed point and
// compares y_value and overflow beat by beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module exp_quadratic_ramp_eval_tb;
    import eqr_pkg::*;

    localparam int FRAC = 16;
    localparam int SETTLE = 60;
    localparam longint LN2Q = 744261118;
    localparam longint ONEQ = 64'sd1 << 30;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] y;
        logic               ovf;
    } ramp_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] x_sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] y_value;
    logic overflow;

    logic signed [31:0] abscissa_q[$];
    ramp_result_t expected_q[$];
    longint coef[7];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int results_seen = 0;
    int ovf_seen = 0;
    bit hold_send = 0;

    exp_quadratic_ramp_eval uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint ramp_exp(longint z, ref bit ovf);
        longint lim, zq, k, r, p, sh;
        lim = 64'sd64 << FRAC;
        if (z > lim)
        begin
            ovf = 1;
            return SMAX;
        end
        if (z < -lim)
            return 0;
        zq = z * (64'sd1 << (30 - FRAC));
        if (zq >= 0)
            k = zq / LN2Q;
        else
            k = -((-zq + LN2Q - 1) / LN2Q);
        r = zq - k * LN2Q;
        p = ONEQ;
        for (int i = 12; i >= 1; i--)
            p = ONEQ + longint'((longint'(unsigned'(r)) * p) >> 30) / i;
        if (p > SMAX)
            p = SMAX;
        sh = k + FRAC - 30;
        if (sh >= 1)
        begin
            ovf = 1;
            return SMAX;
        end
        if (sh == 0)
            return p;
        if (-sh >= 63)
            return 0;
        return p >> (-sh);
    endfunction

    function automatic ramp_result_t eval_ramp(logic signed [31:0] xin);
        ramp_result_t res;
        bit ovf;
        longint x, dx0, dx1, ur, ud, z, e, t_exp, sq, sum;
        bit [127:0] um, sqm;
        ovf = 0;
        x = xin;
        dx0 = x - coef[REG_EXP_ORG];
        dx1 = x - coef[REG_POLY_ORG];
        ur = coef[REG_RATE] < 0 ? -coef[REG_RATE] : coef[REG_RATE];
        ud = dx0 < 0 ? -dx0 : dx0;
        um = 128'(ur) * 128'(ud);
        z = longint'(um >> FRAC);
        if ((coef[REG_RATE] > 0 && dx0 > 0) || (coef[REG_RATE] < 0 && dx0 < 0))
            z = -z - ((um[FRAC-1:0] != 0) ? 1 : 0);
        e = ramp_exp(z, ovf);
        t_exp = fdiv(coef[REG_GOAL] * ((64'sd1 << FRAC) - e), FRAC);
        ud = dx1 < 0 ? -dx1 : dx1;
        sqm = (128'(ud) * 128'(ud)) >> FRAC;
        if (sqm > 128'(SMAX))
        begin
            sqm = 128'(SMAX);
            ovf = 1;
        end
        sq = longint'(sqm);
        sum = fdiv(coef[REG_QUAD] * sq, FRAC) + fdiv(coef[REG_LIN] * dx1, FRAC)
            + t_exp + coef[REG_CONST];
        if (sum > SMAX)
        begin
            sum = SMAX;
            ovf = 1;
        end
        if (sum < SMIN)
        begin
            sum = SMIN;
            ovf = 1;
        end
        res.y = sum[31:0];
        res.ovf = ovf;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s at %0t: got %0h want %0h", what, $realtime, got, want);
    endtask

    // driver: predict at acceptance, keep valid high across back-to-back beats
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            expected_q.push_back(eval_ramp(x_sample));
        if (!in_valid || in_ready)
        begin
            if (abscissa_q.size() > 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                x_sample <= abscissa_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        ramp_result_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (overflow)
                ovf_seen++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", y_value, 0);
            else
            begin
                want = expected_q.pop_front();
                if (y_value !== want.y)
                    report_mismatch("y_value", y_value, want.y);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", overflow, want.ovf);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        coef[idx] = longint'(signed'(val));
    endtask

    task automatic drain;
        while (abscissa_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000);
            3: return -$urandom_range(32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic load_coefs(int mode);
        for (int i = 0; i < 7; i++)
        begin
            case (mode)
                0: write_reg(cfg_reg_t'(i), 32'h0001_0000);
                1: write_reg(cfg_reg_t'(i), 32'h7FFF_FFFF);
                2: write_reg(cfg_reg_t'(i), 32'h8000_0000);
                3: write_reg(cfg_reg_t'(i), 32'h0);
                default: write_reg(cfg_reg_t'(i), rand_word());
            endcase
        end
    endtask

    initial
    begin
        int idle_sets[4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{36, 36}};
        foreach (coef[i]) coef[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed: field extremes and exponential edge regions
        load_coefs(0);
        foreach (idle_sets[i])
            ;
        abscissa_q = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
            32'hFFFF_0000, 32'h0040_0000, 32'hFFC0_0000, 32'h0041_0000,
            32'hFFBF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
            32'hFFFF_FFFF};
        drain();
        load_coefs(1);
        abscissa_q = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        drain();
        load_coefs(2);
        abscissa_q = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        drain();
        // random phases with changing coefficients and idle patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = idle_sets[ph % 4][0];
            recv_stall_pct = idle_sets[ph % 4][1];
            load_coefs(ph == 7 ? 3 : 4);
            write_reg(REG_RATE, $urandom_range(32'h0008_0000) - 32'h0004_0000);
            for (int n = 0; n < 85; n++)
                abscissa_q.push_back(rand_word());
            if (ph == 2)
            begin
                while (abscissa_q.size() > 40)
                    @(posedge clk);
                hold_send = 1;
                while (in_valid || expected_q.size() > 0)
                    @(posedge clk);
                hold_send = 0;
            end
            drain();
        end
        $display("Checked %0d results over 11 coefficient settings, %0d with overflow set.",
            results_seen, ovf_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/eqr_pkg.sv
rtl/eqr_front.sv
rtl/eqr_horner_step.sv
rtl/eqr_back.sv
rtl/exp_quadratic_ramp_eval.sv
verif/exp_quadratic_ramp_eval_tb.sv
